[sv/keyed_slot_table_with_expiry_defines.svh]
// Assertion macros for the keyed slot table with expiry.
// Included by the RTL files that carry concurrent checks; needs no other file.
// Each macro expects signals named clock and reset in the including scope.
`ifndef KEYED_SLOT_TABLE_WITH_EXPIRY_DEFINES_SVH
`define KEYED_SLOT_TABLE_WITH_EXPIRY_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define KSTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define KSTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KSTE_ASSERT_NOW(label, ante, cons, msg)
`define KSTE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[sv/kste_pkg.sv]
// Shared types, constants and helpers for the keyed slot table with expiry.
// Stands alone; every other RTL file imports it.
package kste_pkg;

   localparam int SLOT_COUNT  = 32;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_SLOT_W  = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RENEW_LIFETIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_LIFETIME   = 2'd1;

   localparam logic [15:0] RENEW_LIFETIME_RESET = 16'd200;
   localparam logic [15:0] NEW_LIFETIME_RESET   = 16'd200;

   localparam logic REQ_PLAIN     = 1'b0;
   localparam logic REQ_LIGHTNING = 1'b1;

   localparam logic [1:0] OUTCOME_RENEW    = 2'd0;
   localparam logic [1:0] OUTCOME_ALLOC    = 2'd1;
   localparam logic [1:0] OUTCOME_OVERFLOW = 2'd2;

   typedef struct packed {
      logic               req_type;
      logic [31:0]        now;
      logic signed [15:0] src_entity;
      logic signed [15:0] target_entity;
      logic [11:0]        model_id;
   } req_payload_type;

   typedef struct packed {
      logic [RSP_SLOT_W-1:0] slot_index;
      logic [1:0]            outcome;
      logic signed [15:0]    entity_echo;
   } rsp_payload_type;

   // Classified request as it travels from the front to the back.
   typedef struct packed {
      logic        lightning;
      logic [31:0] now;
      logic [15:0] src;
      logic [15:0] dst;
      logic [11:0] model;
      logic [31:0] renew_expiry;
      logic [31:0] new_expiry;
   } work_type;

   typedef struct packed {
      logic [15:0] entity;
      logic [15:0] dest;
      logic [11:0] model;
      logic [31:0] expiry;
   } slot_type;

   // Front-to-queue handoff.
   typedef struct packed {
      logic     push;
      work_type item;
   } push_type;

   function automatic logic [31:0] sat_add(logic [31:0] t, logic [15:0] life);
      logic [32:0] s;
      s = {1'b0, t} + {17'd0, life};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

[sv/kste_queue.sv]
// Short FIFO of classified requests between the front and the back.
// Depends on kste_pkg for the work item type and depth.
module kste_queue import kste_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type head
);

   work_type           q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = q_mem_ff[rd_ptr_ff];
   assign do_push = push_in.push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= push_in.item;
      end
   end

endmodule

[sv/kste_front.sv]
// Request front end: accepts requests, sorts out the match mode and
// precomputes both candidate expiry times. Depends on kste_pkg.
module kste_front import kste_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic [15:0]     renew_lifetime,
   input  logic [15:0]     new_lifetime,
   output push_type        push_out,
   input  logic            q_full
);

   logic     stage_valid_ff, stage_valid_in;
   work_type stage_item_ff, stage_item_in;
   logic     accept;

   assign req_ready = !stage_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      stage_item_in.lightning    = (req_payload.req_type == REQ_LIGHTNING);
      stage_item_in.now          = req_payload.now;
      stage_item_in.src          = req_payload.src_entity;
      stage_item_in.dst          = req_payload.target_entity;
      stage_item_in.model        = req_payload.model_id;
      stage_item_in.renew_expiry = sat_add(req_payload.now, renew_lifetime);
      stage_item_in.new_expiry   = sat_add(req_payload.now, new_lifetime);
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (!q_full) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= stage_item_in;
      end
   end

   assign push_out.push = stage_valid_ff;
   assign push_out.item = stage_item_ff;

endmodule

[sv/kste_back.sv]
// Table engine: scans the slot memory one entry a cycle, then renews or
// allocates a slot (or reports overflow) and loads the response register.
// Depends on kste_pkg and the assertion macros header.
`include "keyed_slot_table_with_expiry_defines.svh"
module kste_back import kste_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  work_type        q_head,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   logic [1:0]        state_ff, state_in;
   work_type          cur_ff;
   logic [SLOT_W-1:0] iss_idx_ff, iss_idx_in;
   logic              iss_on_ff, iss_on_in;
   logic              rd_en;
   logic              rd_vld_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   slot_type          rd_data_ff;
   logic              rd_live_ff;
   slot_type          entry;
   logic              hit, is_free;

   logic              match_hit_ff, match_hit_in;
   logic [SLOT_W-1:0] match_idx_ff, match_idx_in;
   logic [15:0]       match_dest_ff, match_dest_in;
   logic              free_hit_ff, free_hit_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [15:0]       free_dest_ff, free_dest_in;

   slot_type          tbl_mem [SLOT_COUNT];
   logic              live_ff [SLOT_COUNT];
   logic              tbl_we;
   logic [SLOT_W-1:0] sel_idx;
   slot_type          wr_entry;

   logic              rsp_free, rsp_load;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign rd_en    = (state_ff == ST_SCAN) && iss_on_ff;
   assign rsp_load = (state_ff == ST_WRITE) && rsp_free;
   assign tbl_we   = rsp_load && (match_hit_ff || free_hit_ff);
   assign sel_idx  = match_hit_ff ? match_idx_ff : free_idx_ff;

   // Entries never written since reset read as all zero.
   assign entry   = rd_live_ff ? rd_data_ff : '0;
   assign hit     = (entry.entity == cur_ff.src) &&
                    (!cur_ff.lightning || (entry.dest == cur_ff.dst));
   assign is_free = (entry.model == '0) || (entry.expiry < cur_ff.now);

   always_comb begin
      state_in      = state_ff;
      iss_idx_in    = iss_idx_ff;
      iss_on_in     = iss_on_ff;
      match_hit_in  = match_hit_ff;
      match_idx_in  = match_idx_ff;
      match_dest_in = match_dest_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      free_dest_in  = free_dest_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in     = ST_SCAN;
               iss_idx_in   = '0;
               iss_on_in    = 1'b1;
               match_hit_in = 1'b0;
               free_hit_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            if (iss_on_ff) begin
               if (iss_idx_ff == LAST_SLOT) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff + 1'b1;
               end
            end
            if (rd_vld_ff) begin
               if (hit && !match_hit_ff) begin
                  match_hit_in  = 1'b1;
                  match_idx_in  = rd_idx_ff;
                  match_dest_in = entry.dest;
               end
               if (is_free && !free_hit_ff) begin
                  free_hit_in  = 1'b1;
                  free_idx_in  = rd_idx_ff;
                  free_dest_in = entry.dest;
               end
               if (rd_idx_ff == LAST_SLOT) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wr_entry.entity = cur_ff.src;
      wr_entry.model  = cur_ff.model;
      wr_entry.dest   = cur_ff.lightning ? cur_ff.dst
                                         : (match_hit_ff ? match_dest_ff : free_dest_ff);
      wr_entry.expiry = match_hit_ff ? cur_ff.renew_expiry : cur_ff.new_expiry;

      rsp_in.entity_echo = cur_ff.src;
      if (match_hit_ff) begin
         rsp_in.slot_index = RSP_SLOT_W'(sel_idx);
         rsp_in.outcome    = OUTCOME_RENEW;
      end else if (free_hit_ff) begin
         rsp_in.slot_index = RSP_SLOT_W'(sel_idx);
         rsp_in.outcome    = OUTCOME_ALLOC;
      end else begin
         rsp_in.slot_index = '0;
         rsp_in.outcome    = OUTCOME_OVERFLOW;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_on_ff    <= 1'b0;
         rd_vld_ff    <= 1'b0;
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_on_ff    <= iss_on_in;
         rd_vld_ff    <= rd_en;
         match_hit_ff <= match_hit_in;
         free_hit_ff  <= free_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_idx_ff    <= iss_idx_in;
      match_idx_ff  <= match_idx_in;
      match_dest_ff <= match_dest_in;
      free_idx_ff   <= free_idx_in;
      free_dest_ff  <= free_dest_in;
      rd_idx_ff     <= iss_idx_ff;
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Slot memory: one read port with registered data, one write port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tbl_mem[iss_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[sel_idx] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            live_ff[i] <= 1'b0;
         end
         rd_live_ff <= 1'b0;
      end else begin
         if (tbl_we) begin
            live_ff[sel_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_live_ff <= live_ff[iss_idx_ff];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `KSTE_ASSERT_NOW(a_pop_only_idle, q_pop, state_ff == ST_IDLE && !q_empty, "pop outside idle")
   `KSTE_ASSERT_NOW(a_no_read_on_write, tbl_we, !rd_en, "table write while scanning")
   `KSTE_ASSERT_NEXT(a_last_compare_to_write, state_ff == ST_SCAN && rd_vld_ff && rd_idx_ff == LAST_SLOT, state_ff == ST_WRITE, "scan did not finish")
   `KSTE_ASSERT_NEXT(a_overflow_zero_index, rsp_load && !match_hit_ff && !free_hit_ff, rsp_valid && rsp_payload.slot_index == '0 && rsp_payload.outcome == OUTCOME_OVERFLOW, "bad overflow response")

endmodule

[sv/keyed_slot_table_with_expiry.sv]
// Top level of the keyed slot table with expiry: lifetime registers,
// front end, request queue and table engine. Depends on kste_pkg,
// kste_front, kste_queue and kste_back.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_valid/req_ready  req_payload_type
//   rsp_*     out        rsp_valid/rsp_ready  rsp_payload_type
//   csr_*     in         csr_we               csr_index, csr_wdata
//
// Each request goes through the table engine in order: it is picked from the queue,
// every slot is streamed through the single memory read port and compared, and
// then the chosen slot is written. Ahead of the engine the request passes
// through the front stage and the queue, each of which holds it in a register.
// Synchronous reset marks every slot unwritten (reads as zero, so free) and
// loads both lifetimes with 200. No sweep over the memory is needed.
// A stalled response holds the engine in its write step; the front stage and
// queue keep taking requests until they fill.
module keyed_slot_table_with_expiry import kste_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [15:0] renew_lifetime_ff, renew_lifetime_in;
   logic [15:0] new_lifetime_ff, new_lifetime_in;
   push_type    push;
   logic        q_full, q_empty, q_pop;
   work_type    q_head;

   // Decode lifetime writes; drop writes to unknown indexes.
   always_comb begin
      renew_lifetime_in = renew_lifetime_ff;
      new_lifetime_in   = new_lifetime_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RENEW_LIFETIME: renew_lifetime_in = csr_wdata[15:0];
            CSR_NEW_LIFETIME:   new_lifetime_in   = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         renew_lifetime_ff <= RENEW_LIFETIME_RESET;
         new_lifetime_ff   <= NEW_LIFETIME_RESET;
      end else begin
         renew_lifetime_ff <= renew_lifetime_in;
         new_lifetime_ff   <= new_lifetime_in;
      end
   end

   // Front: accept the request and precompute both saturated expiry times.
   kste_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .renew_lifetime (renew_lifetime_ff),
      .new_lifetime   (new_lifetime_ff),
      .push_out       (push),
      .q_full         (q_full)
   );

   // Queue: decouple request intake from the slot scan.
   kste_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head    (q_head)
   );

   // Back: scan the slots, renew or allocate, present the response.
   kste_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
